// ----- rtl/core/phc_pkg.sv -----
package phc_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned MaxVerticesDef = 32;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLineAx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLineAy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLineBx = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLineBy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeepLeft = 3'd4;

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = -24'sh800000;

  // request from the sequencer to the divider
  typedef struct packed {
    logic        start;
    logic [25:0] mag_d;
    logic [49:0] mag_s;
    logic [50:0] mag_den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [26:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/core/phc_div.sv -----
// Shared restoring divider for the crossing offset: round(m * s / den),
// one bit of m per cycle (26 steps plus one rounding step).
module phc_div
  import phc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [4:0]  bit_q, bit_d;
  logic        busy_q, busy_d;
  logic [25:0] m_q, m_d;
  logic [49:0] s_q, s_d;
  logic [50:0] den_q, den_d;
  logic [52:0] rem_q, rem_d;
  logic [26:0] quo_q, quo_d;
  logic        done_q, done_d;
  logic        fin_q, fin_d;
  logic [52:0] r1, r2;
  logic [26:0] q1;

  // one shift-add-subtract step
  always_comb begin
    r1 = {rem_q[51:0], 1'b0} + (m_q[25] ? {3'b0, s_q} : 53'd0);
    q1 = {quo_q[25:0], 1'b0};
    if (r1 >= {2'b0, den_q}) begin
      r1 = r1 - {2'b0, den_q};
      q1 = q1 + 27'd1;
    end
    r2 = r1;
    if (r2 >= {2'b0, den_q}) begin
      r2 = r2 - {2'b0, den_q};
      q1 = q1 + 27'd1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    bit_d  = bit_q;
    m_d    = m_q;
    s_d    = s_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    fin_d  = fin_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      fin_d  = 1'b0;
      bit_d  = 5'd25;
      m_d    = req_i.mag_d;
      s_d    = req_i.mag_s;
      den_d  = req_i.mag_den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q && fin_q) begin
      // round half up on the remainder
      if ({rem_q[51:0], 1'b0} >= {2'b0, den_q}) quo_d = quo_q + 27'd1;
      busy_d = 1'b0;
      done_d = 1'b1;
    end else if (busy_q) begin
      rem_d = r2;
      quo_d = q1;
      m_d   = {m_q[24:0], 1'b0};
      if (bit_q == 5'd0) fin_d = 1'b1;
      else bit_d = bit_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      fin_q  <= fin_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    s_q   <= s_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- rtl/core/polygon_half_plane_clip.sv -----
// Each vertex request is taken and stored and gives no result. The last vertex
// starts the clip: per input edge, reads, products and side tests; per crossing,
// two runs of the shared bit-serial divider; a closing step, then one result per
// cycle after a registered read of the clipped memory.
// Busy stays high from the last vertex until the final result strobe; the
// receiver cannot stall. Reset clears control, keeps the left side.
module polygon_half_plane_clip
  import phc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CoordW-1:0]         cfg_wdata_i,
  input  logic signed [CoordW-1:0]  vertex_x_i,
  input  logic signed [CoordW-1:0]  vertex_y_i,
  input  logic                      vertex_last_i,
  output logic                      out_valid_o,
  output logic signed [CoordW-1:0]  out_x_o,
  output logic signed [CoordW-1:0]  out_y_o,
  output logic                      out_last_o,
  output logic                      out_empty_o
);

  localparam int unsigned ClipMax = (MAX_VERTICES * 3) / 2;
  localparam int unsigned InAw = $clog2(MAX_VERTICES);
  localparam int unsigned ClAw = $clog2(ClipMax);
  localparam int unsigned InCw = $clog2(MAX_VERTICES + 1);
  localparam int unsigned ClCw = $clog2(ClipMax + 1);

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdP   = 4'd1;
  localparam logic [3:0] StMulA  = 4'd2;
  localparam logic [3:0] StMulB  = 4'd3;
  localparam logic [3:0] StSide  = 4'd4;
  localparam logic [3:0] StKeepP = 4'd5;
  localparam logic [3:0] StDivX  = 4'd6;
  localparam logic [3:0] StDivY  = 4'd7;
  localparam logic [3:0] StKeepC = 4'd8;
  localparam logic [3:0] StNext  = 4'd9;
  localparam logic [3:0] StClose = 4'd10;
  localparam logic [3:0] StEmit  = 4'd11;
  localparam logic [3:0] StEmpty = 4'd12;
  localparam logic [3:0] StEcho  = 4'd13;
  localparam logic [3:0] StWaitX = 4'd14;
  localparam logic [3:0] StWaitY = 4'd15;

  // configuration registers
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic                     left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
      left_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLineAx:   ax_q <= cfg_wdata_i;
        RegLineAy:   ay_q <= cfg_wdata_i;
        RegLineBx:   bx_q <= cfg_wdata_i;
        RegLineBy:   by_q <= cfg_wdata_i;
        RegKeepLeft: left_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input vertex memory
  logic signed [CoordW-1:0] inx_mem [MAX_VERTICES];
  logic signed [CoordW-1:0] iny_mem [MAX_VERTICES];
  logic [InCw-1:0] in_cnt_q;
  logic [InAw-1:0] in_raddr;
  logic signed [CoordW-1:0] in_rx_q, in_ry_q;
  logic accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept && in_cnt_q < InCw'(MAX_VERTICES)) begin
      inx_mem[in_cnt_q[InAw-1:0]] <= vertex_x_i;
      iny_mem[in_cnt_q[InAw-1:0]] <= vertex_y_i;
    end
    in_rx_q <= inx_mem[in_raddr];
    in_ry_q <= iny_mem[in_raddr];
  end

  // clipped vertex memory
  logic signed [CoordW-1:0] clx_mem [ClipMax];
  logic signed [CoordW-1:0] cly_mem [ClipMax];
  logic [ClAw-1:0] cl_raddr;
  logic            cl_we;
  logic signed [CoordW-1:0] cl_wx, cl_wy, cl_rx_q, cl_ry_q;
  logic [ClCw-1:0] cl_cnt_q, cl_cnt_d;

  always_ff @(posedge clk_i) begin
    if (cl_we) begin
      clx_mem[cl_cnt_q[ClAw-1:0]] <= cl_wx;
      cly_mem[cl_cnt_q[ClAw-1:0]] <= cl_wy;
    end
    cl_rx_q <= clx_mem[cl_raddr];
    cl_ry_q <= cly_mem[cl_raddr];
  end

  // sequencer registers
  logic [3:0] st_q, st_d;
  logic [ClCw-1:0] n_q, n_d, i_q, i_d;
  logic [ClCw-1:0] k_q, k_d;
  logic phase_q, phase_d;  // 0: working on p, 1: on q
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d, qx_q, qx_d, qy_q, qy_d;
  logic signed [CoordW-1:0] fx_q, fx_d, fy_q, fy_d;  // first kept
  logic signed [CoordW-1:0] lx_q, lx_d, ly_q, ly_d;  // last kept
  logic signed [CoordW-1:0] cx_q, cx_d;
  logic signed [49:0] prod_q, prod_d;
  logic signed [50:0] sp_q, sp_d, sq_q, sq_d;
  logic signed [CoordW:0] rx, ry;
  logic busy_q, busy_d;
  logic ov_q, ov_d, ol_q, ol_d, oe_q, oe_d;
  logic signed [CoordW-1:0] ox_q, ox_d, oy_q, oy_d;
  div_req_t dreq;
  div_rsp_t drsp;

  assign rx = 25'(bx_q) - 25'(ax_q);
  assign ry = 25'(by_q) - 25'(ay_q);

  // shared multiplier: 25x25 signed, one product per cycle
  logic signed [CoordW:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  logic signed [CoordW-1:0] vx, vy;
  assign vx = phase_q ? qx_q : px_q;
  assign vy = phase_q ? qy_q : py_q;
  always_comb begin
    if (st_q == StMulA) begin
      mul_a = rx;
      mul_b = 25'(vy) - 25'(ay_q);
    end else begin
      mul_a = ry;
      mul_b = 25'(vx) - 25'(ax_q);
    end
    mul_p = mul_a * mul_b;
  end

  // divider operands
  logic signed [CoordW:0] dd;
  logic signed [50:0] den;
  logic signed [CoordW+1:0] crs;
  logic signed [CoordW-1:0] crs_sat;
  always_comb begin
    dd  = (st_q == StDivX || st_q == StWaitX) ? 25'(qx_q) - 25'(px_q)
                                              : 25'(qy_q) - 25'(py_q);
    den = sp_q - sq_q;
    dreq.start   = (st_q == StDivX || st_q == StDivY);
    dreq.mag_d   = 26'(dd[CoordW] ? -26'(dd) : 26'(dd));
    dreq.mag_s   = sp_q[50] ? 50'(-sp_q) : 50'(sp_q);
    dreq.mag_den = den[50] ? 51'(-den) : 51'(den);
    crs = dd[CoordW] ? 26'(st_q == StWaitX ? px_q : py_q) - 26'(drsp.quo)
                     : 26'(st_q == StWaitX ? px_q : py_q) + 26'(drsp.quo);
    if (crs > 26'(CoordMax)) crs_sat = CoordMax;
    else if (crs < 26'(CoordMin)) crs_sat = CoordMin;
    else crs_sat = crs[CoordW-1:0];
  end

  phc_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (dreq),
    .rsp_o (drsp)
  );

  // append with duplicate suppression
  logic app_en;
  logic signed [CoordW-1:0] app_x, app_y;
  always_comb begin
    cl_we = 1'b0;
    cl_wx = app_x;
    cl_wy = app_y;
    cl_cnt_d = cl_cnt_q;
    if (app_en && !(cl_cnt_q != '0 && lx_q == app_x && ly_q == app_y)
        && cl_cnt_q < ClCw'(ClipMax)) begin
      cl_we = 1'b1;
      cl_cnt_d = cl_cnt_q + 1'b1;
    end
  end

  logic [ClCw-1:0] inext;
  assign inext = (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;

  // main sequencer
  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; k_d = k_q; phase_d = phase_q;
    px_d = px_q; py_d = py_q; qx_d = qx_q; qy_d = qy_q;
    fx_d = fx_q; fy_d = fy_q; lx_d = lx_q; ly_d = ly_q; cx_d = cx_q;
    prod_d = prod_q; sp_d = sp_q; sq_d = sq_q;
    busy_d = busy_q;
    ov_d = 1'b0; ol_d = 1'b0; oe_d = 1'b0; ox_d = ox_q; oy_d = oy_q;
    app_en = 1'b0; app_x = px_q; app_y = py_q;
    in_raddr = '0;
    cl_raddr = '0;
    case (st_q)
      StIdle: begin
        if (accept && vertex_last_i) begin
          n_d = (in_cnt_q < InCw'(MAX_VERTICES)) ? ClCw'(in_cnt_q) + 1'b1
                                                 : ClCw'(in_cnt_q);
          busy_d = 1'b1;
          i_d = '0;
          k_d = '0;
          if (n_d < ClCw'(3)) st_d = StEmpty;
          else if (rx == '0 && ry == '0) st_d = StEcho;
          else st_d = StRdP;
        end
      end
      StRdP: begin
        // address p when k is 0, q when k is 1; data lands in the next cycle
        in_raddr = (k_q == ClCw'(0)) ? i_q[InAw-1:0] : inext[InAw-1:0];
        if (k_q == ClCw'(0)) k_d = ClCw'(1);
        else if (k_q == ClCw'(1)) begin
          px_d = in_rx_q; py_d = in_ry_q; k_d = ClCw'(2);
          phase_d = 1'b1;
        end else begin
          qx_d = in_rx_q; qy_d = in_ry_q; k_d = '0;
          phase_d = 1'b0;
          st_d = StMulA;
        end
      end
      StMulA: begin
        prod_d = mul_p;
        st_d = StMulB;
      end
      StMulB: begin
        sp_d = phase_q ? sp_q : 51'(prod_q) - 51'(mul_p);
        sq_d = phase_q ? 51'(prod_q) - 51'(mul_p) : sq_q;
        st_d = StSide;
      end
      StSide: begin
        if (!phase_q) begin
          if (!left_q) sp_d = -sp_q;
          phase_d = 1'b1;
          st_d = StMulA;
        end else begin
          if (!left_q) sq_d = -sq_q;
          phase_d = 1'b0;
          st_d = StKeepP;
        end
      end
      StKeepP: begin
        app_en = !sp_q[50];
        app_x = px_q; app_y = py_q;
        if (cl_we) begin
          lx_d = px_q; ly_d = py_q;
          if (cl_cnt_q == '0) begin fx_d = px_q; fy_d = py_q; end
        end
        st_d = (sp_q[50] != sq_q[50]) ? StDivX : StNext;
      end
      StDivX: st_d = StWaitX;
      StWaitX: begin
        if (drsp.done) begin
          cx_d = crs_sat;
          st_d = StDivY;
        end
      end
      StDivY: st_d = StWaitY;
      StWaitY: begin
        if (drsp.done) begin
          app_en = 1'b1;
          app_x = cx_q; app_y = crs_sat;
          if (cl_we) begin
            lx_d = cx_q; ly_d = crs_sat;
            if (cl_cnt_q == '0) begin fx_d = cx_q; fy_d = crs_sat; end
          end
          st_d = StNext;
        end
      end
      StNext: begin
        if (i_q + 1'b1 == n_q) st_d = StClose;
        else begin
          i_d = i_q + 1'b1;
          st_d = StRdP;
        end
      end
      StClose: begin
        k_d = '0;
        if (cl_cnt_q > ClCw'(1) && fx_q == lx_q && fy_q == ly_q)
          n_d = cl_cnt_q - 1'b1;
        else n_d = cl_cnt_q;
        st_d = (n_d < ClCw'(3)) ? StEmpty : StEmit;
      end
      StEmit: begin
        // read one ahead; k counts reads
        cl_raddr = k_q[ClAw-1:0];
        if (k_q != n_q) k_d = k_q + 1'b1;
        if (k_q != '0) begin
          ov_d = 1'b1;
          ox_d = cl_rx_q; oy_d = cl_ry_q;
          if (k_q == n_q) begin
            ol_d = 1'b1;
            busy_d = 1'b0;
            st_d = StIdle;
          end
        end
      end
      StEcho: begin
        in_raddr = k_q[InAw-1:0];
        if (k_q != n_q) k_d = k_q + 1'b1;
        if (k_q != '0) begin
          ov_d = 1'b1;
          ox_d = in_rx_q; oy_d = in_ry_q;
          if (k_q == n_q) begin
            ol_d = 1'b1;
            busy_d = 1'b0;
            st_d = StIdle;
          end
        end
      end
      StEmpty: begin
        ov_d = 1'b1; ol_d = 1'b1; oe_d = 1'b1;
        ox_d = '0; oy_d = '0;
        busy_d = 1'b0;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // stored vertex count, cleared by the last vertex
  logic [InCw-1:0] in_cnt_d;
  always_comb begin
    in_cnt_d = in_cnt_q;
    if (accept) begin
      if (vertex_last_i) in_cnt_d = '0;
      else if (in_cnt_q < InCw'(MAX_VERTICES)) in_cnt_d = in_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      busy_q <= 1'b0;
      in_cnt_q <= '0;
      cl_cnt_q <= '0;
      ov_q <= 1'b0;
      ol_q <= 1'b0;
      oe_q <= 1'b0;
      phase_q <= 1'b0;
      k_q <= '0;
      i_q <= '0;
      n_q <= '0;
    end else begin
      st_q <= st_d;
      busy_q <= busy_d;
      in_cnt_q <= in_cnt_d;
      cl_cnt_q <= (st_q == StIdle) ? '0 : cl_cnt_d;
      ov_q <= ov_d;
      ol_q <= ol_d;
      oe_q <= oe_d;
      phase_q <= phase_d;
      k_q <= k_d;
      i_q <= i_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; qx_q <= qx_d; qy_q <= qy_d;
    fx_q <= fx_d; fy_q <= fy_d; lx_q <= lx_d; ly_q <= ly_d;
    cx_q <= cx_d; prod_q <= prod_d; sp_q <= sp_d; sq_q <= sq_d;
    ox_q <= ox_d; oy_q <= oy_d;
  end

  assign busy        = busy_q;
  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_last_o  = ol_q;
  assign out_empty_o = oe_q;

endmodule

// ----- rtl/core/phc_checker.sv -----
module phc_sva
  import phc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic out_valid_o,
  input logic out_last_o,
  input logic out_empty_o,
  input logic signed [CoordW-1:0] out_x_o,
  input logic signed [CoordW-1:0] out_y_o
);

  // an empty result is a single final item at the origin
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_empty_o |-> out_last_o && out_x_o == '0 && out_y_o == '0)
    else $error("empty result malformed");

  // results come only while a polygon is in work
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("result outside a clip");

  // the final result frees the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> !busy)
    else $error("busy after final result");

  // after the final result, no stray strobe
  a_no_trailing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |=> !out_valid_o)
    else $error("strobe after final result");

endmodule

bind polygon_half_plane_clip phc_sva u_phc_sva (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .out_valid_o,
  .out_last_o,
  .out_empty_o,
  .out_x_o,
  .out_y_o
);
